// ===== rtl/tama_pkg.sv =====
`default_nettype none

package tama_pkg;

  // window length in samples
  localparam int WINDOW = 8;
  localparam int AXES = 3;
  localparam int SAMPLE_W = 16;

  // sum of WINDOW samples cannot overflow at this width
  localparam int SUM_W = SAMPLE_W + $clog2(WINDOW);
  localparam int CNT_W = $clog2(WINDOW + 1);
  localparam int PTR_W = $clog2(WINDOW);
  localparam int HIST_W = AXES * SAMPLE_W;

  // one quotient bit per divider step
  localparam int STEP_W = $clog2(SUM_W);

  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W = $clog2(QUEUE_DEPTH + 1);

  typedef logic signed [SAMPLE_W-1:0] sample_t;
  typedef logic signed [SUM_W-1:0] sum_t;
  typedef logic [CNT_W-1:0] count_t;

  // work handed from the front to the divider
  typedef struct packed {
    sum_t   sum_x;
    sum_t   sum_y;
    sum_t   sum_z;
    count_t count;
    logic   window_full;
  } job_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_status_t;

  typedef enum logic {
    F_IDLE,
    F_UPDATE
  } front_state_t;

  typedef enum logic [1:0] {
    B_IDLE,
    B_RUN,
    B_DONE
  } back_state_t;

endpackage

`default_nettype wire

// ===== rtl/tama_front.sv =====
`default_nettype none

module tama_front (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              push,
  output logic                   full,
  input  wire tama_pkg::sample_t sample_x,
  input  wire tama_pkg::sample_t sample_y,
  input  wire tama_pkg::sample_t sample_z,
  input  wire tama_pkg::q_status_t q_status,
  output logic                   q_wr,
  output tama_pkg::job_t         q_data
);

  tama_pkg::front_state_t state, state_next;

  tama_pkg::sample_t smp_x, smp_y, smp_z;
  tama_pkg::sum_t sum_x, sum_y, sum_z;
  tama_pkg::sum_t sum_x_next, sum_y_next, sum_z_next;
  tama_pkg::count_t count, count_next;
  logic [tama_pkg::PTR_W-1:0] wp, wp_next;

  logic [tama_pkg::HIST_W-1:0] hist [tama_pkg::WINDOW];
  logic [tama_pkg::HIST_W-1:0] rd_data;

  tama_pkg::sample_t old_x, old_y, old_z;
  tama_pkg::sum_t drop_x, drop_y, drop_z;
  logic full_before;
  logic upd;

  // next state
  always_comb begin
    state_next = state;
    case (state)
      tama_pkg::F_IDLE:   if (push) state_next = tama_pkg::F_UPDATE;
      tama_pkg::F_UPDATE: if (!q_status.full) state_next = tama_pkg::F_IDLE;
      default:            state_next = tama_pkg::F_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    full = 1'b1;
    upd  = 1'b0;
    case (state)
      tama_pkg::F_IDLE:   full = 1'b0;
      tama_pkg::F_UPDATE: upd = !q_status.full;
      default:            full = 1'b1;
    endcase
  end

  assign old_x = rd_data[tama_pkg::SAMPLE_W-1:0];
  assign old_y = rd_data[2*tama_pkg::SAMPLE_W-1:tama_pkg::SAMPLE_W];
  assign old_z = rd_data[3*tama_pkg::SAMPLE_W-1:2*tama_pkg::SAMPLE_W];

  assign full_before = (count == tama_pkg::CNT_W'(tama_pkg::WINDOW));

  // oldest sample leaves only once the window is full
  assign drop_x = full_before ? tama_pkg::sum_t'(old_x) : '0;
  assign drop_y = full_before ? tama_pkg::sum_t'(old_y) : '0;
  assign drop_z = full_before ? tama_pkg::sum_t'(old_z) : '0;

  assign sum_x_next = sum_x - drop_x + tama_pkg::sum_t'(smp_x);
  assign sum_y_next = sum_y - drop_y + tama_pkg::sum_t'(smp_y);
  assign sum_z_next = sum_z - drop_z + tama_pkg::sum_t'(smp_z);

  assign count_next = full_before ? count : count + 1'b1;
  assign wp_next = (wp == tama_pkg::PTR_W'(tama_pkg::WINDOW - 1)) ? '0 : wp + 1'b1;

  assign q_wr = upd;
  assign q_data.sum_x = sum_x_next;
  assign q_data.sum_y = sum_y_next;
  assign q_data.sum_z = sum_z_next;
  assign q_data.count = count_next;
  assign q_data.window_full = (count_next == tama_pkg::CNT_W'(tama_pkg::WINDOW));

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= tama_pkg::F_IDLE;
      sum_x <= '0;
      sum_y <= '0;
      sum_z <= '0;
      count <= '0;
      wp    <= '0;
    end else begin
      state <= state_next;
      if (upd) begin
        sum_x <= sum_x_next;
        sum_y <= sum_y_next;
        sum_z <= sum_z_next;
        count <= count_next;
        wp    <= wp_next;
      end
    end
  end

  // sample beat capture
  always_ff @(posedge clk) begin
    if (state == tama_pkg::F_IDLE && push) begin
      smp_x <= sample_x;
      smp_y <= sample_y;
      smp_z <= sample_z;
    end
  end

  // history ring, read ahead at the write pointer
  always_ff @(posedge clk) begin
    rd_data <= hist[wp];
    if (upd) begin
      hist[wp] <= {smp_z, smp_y, smp_x};
    end
  end

  assert property (@(posedge clk) disable iff (rst)
    count <= tama_pkg::CNT_W'(tama_pkg::WINDOW))
    else $error("fill count beyond window");

  assert property (@(posedge clk) disable iff (rst)
    !full_before |-> (tama_pkg::CNT_W'(wp) == count))
    else $error("write pointer out of step with fill count");

endmodule

`default_nettype wire

// ===== rtl/tama_fifo.sv =====
`default_nettype none

module tama_fifo (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           wr,
  input  wire tama_pkg::job_t wr_data,
  input  wire logic           rd,
  output tama_pkg::job_t      rd_data,
  output tama_pkg::q_status_t status
);

  tama_pkg::job_t entry [tama_pkg::QUEUE_DEPTH];
  logic [tama_pkg::QPTR_W-1:0] wr_ptr, rd_ptr;
  logic [tama_pkg::QCNT_W-1:0] level;

  function automatic logic [tama_pkg::QPTR_W-1:0] bump(input logic [tama_pkg::QPTR_W-1:0] p);
    bump = (p == tama_pkg::QPTR_W'(tama_pkg::QUEUE_DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  assign status.full  = (level == tama_pkg::QCNT_W'(tama_pkg::QUEUE_DEPTH));
  assign status.empty = (level == '0);
  assign rd_data = entry[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      level  <= '0;
    end else begin
      if (wr) wr_ptr <= bump(wr_ptr);
      if (rd) rd_ptr <= bump(rd_ptr);
      if (wr && !rd) level <= level + 1'b1;
      else if (rd && !wr) level <= level - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (wr) entry[wr_ptr] <= wr_data;
  end

  assert property (@(posedge clk) disable iff (rst)
    (wr |-> !status.full) and (rd |-> !status.empty))
    else $error("queue overrun or underrun");

endmodule

`default_nettype wire

// ===== rtl/tama_div.sv =====
`default_nettype none

module tama_div (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire tama_pkg::q_status_t q_status,
  input  wire tama_pkg::job_t      q_data,
  output logic                     q_rd,
  input  wire logic                pop,
  output logic                     empty,
  output tama_pkg::sample_t        average_x,
  output tama_pkg::sample_t        average_y,
  output tama_pkg::sample_t        average_z,
  output logic                     window_full
);

  localparam int SW = tama_pkg::SUM_W;
  localparam int CW = tama_pkg::CNT_W;

  tama_pkg::back_state_t state, state_next;

  logic [SW-1:0] num [tama_pkg::AXES];
  logic [CW-1:0] rem [tama_pkg::AXES];
  logic          neg [tama_pkg::AXES];
  logic [SW-1:0] num_next [tama_pkg::AXES];
  logic [CW-1:0] rem_next [tama_pkg::AXES];
  logic [SW-1:0] mag [tama_pkg::AXES];
  logic [SW-1:0] quo [tama_pkg::AXES];
  tama_pkg::sum_t lane_sum [tama_pkg::AXES];

  tama_pkg::count_t div;
  logic job_full;
  logic [tama_pkg::STEP_W-1:0] step;

  tama_pkg::sample_t avg [tama_pkg::AXES];
  logic out_full;
  logic out_valid;
  logic load_out;

  assign lane_sum[0] = q_data.sum_x;
  assign lane_sum[1] = q_data.sum_y;
  assign lane_sum[2] = q_data.sum_z;

  // restoring division, one quotient bit per cycle in each lane
  always_comb begin
    logic [CW:0] rem_sh;
    logic        ge;
    for (int i = 0; i < tama_pkg::AXES; i++) begin
      rem_sh = {rem[i], num[i][SW-1]};
      ge = (rem_sh >= {1'b0, div});
      rem_next[i] = ge ? CW'(rem_sh - {1'b0, div}) : rem_sh[CW-1:0];
      num_next[i] = {num[i][SW-2:0], ge};
      mag[i] = lane_sum[i][SW-1] ? SW'(-lane_sum[i]) : SW'(lane_sum[i]);
      quo[i] = neg[i] ? SW'(-num[i]) : num[i];
    end
  end

  // next state
  always_comb begin
    state_next = state;
    case (state)
      tama_pkg::B_IDLE: if (!q_status.empty) state_next = tama_pkg::B_RUN;
      tama_pkg::B_RUN:  if (step == '0) state_next = tama_pkg::B_DONE;
      tama_pkg::B_DONE: if (!out_valid || pop) state_next = tama_pkg::B_IDLE;
      default:          state_next = tama_pkg::B_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    q_rd = 1'b0;
    load_out = 1'b0;
    case (state)
      tama_pkg::B_IDLE: q_rd = !q_status.empty;
      tama_pkg::B_DONE: load_out = !out_valid || pop;
      default:          q_rd = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= tama_pkg::B_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (load_out) out_valid <= 1'b1;
      else if (pop) out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (q_rd) begin
      div <= q_data.count;
      job_full <= q_data.window_full;
      step <= tama_pkg::STEP_W'(SW - 1);
      for (int i = 0; i < tama_pkg::AXES; i++) begin
        num[i] <= mag[i];
        rem[i] <= '0;
        neg[i] <= lane_sum[i][SW-1];
      end
    end else if (state == tama_pkg::B_RUN) begin
      step <= step - 1'b1;
      for (int i = 0; i < tama_pkg::AXES; i++) begin
        num[i] <= num_next[i];
        rem[i] <= rem_next[i];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      out_full <= job_full;
      for (int i = 0; i < tama_pkg::AXES; i++) begin
        avg[i] <= quo[i][tama_pkg::SAMPLE_W-1:0];
      end
    end
  end

  assign empty = !out_valid;
  assign average_x = avg[0];
  assign average_y = avg[1];
  assign average_z = avg[2];
  assign window_full = out_full;

  assert property (@(posedge clk) disable iff (rst)
    (state == tama_pkg::B_RUN) |-> (div != '0))
    else $error("divider running with zero count");

  assert property (@(posedge clk) disable iff (rst)
    load_out |=> !empty)
    else $error("finished result not presented");

endmodule

`default_nettype wire

// ===== rtl/three_axis_moving_average.sv =====
`default_nettype none

// channel    direction  handshake            payload
// sample     in         push / full          sample_x, sample_y, sample_z
// average    out        pop / empty          average_x, average_y, average_z, window_full
//
// the front takes a sample beat in idle, where the registered history read at the
// write pointer runs, then does the running-sum update and history write in update
// (held while the queue is full) before the next beat; the divider runs a restoring
// divide, one bit per cycle, three axes in parallel, and this sets the sustained rate
// a 2-entry queue sits between front and divider, the output register holds one result
// rst clears sums, fill count, pointer, queue and both controllers; history is not cleared
// a stalled output only stops the divider; the front keeps going until the queue fills

module three_axis_moving_average (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              push,
  output logic                   full,
  input  wire tama_pkg::sample_t sample_x,
  input  wire tama_pkg::sample_t sample_y,
  input  wire tama_pkg::sample_t sample_z,
  output logic                   empty,
  input  wire logic              pop,
  output tama_pkg::sample_t      average_x,
  output tama_pkg::sample_t      average_y,
  output tama_pkg::sample_t      average_z,
  output logic                   window_full
);

  // front to queue
  logic           q_wr;
  tama_pkg::job_t q_wr_data;

  // queue to divider
  logic                q_rd;
  tama_pkg::job_t      q_rd_data;
  tama_pkg::q_status_t q_status;

  // sample beat in, sums updated, job queued
  tama_front u_front (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .full     (full),
    .sample_x (sample_x),
    .sample_y (sample_y),
    .sample_z (sample_z),
    .q_status (q_status),
    .q_wr     (q_wr),
    .q_data   (q_wr_data)
  );

  // short decoupling queue of running sums and counts
  tama_fifo u_fifo (
    .clk     (clk),
    .rst     (rst),
    .wr      (q_wr),
    .wr_data (q_wr_data),
    .rd      (q_rd),
    .rd_data (q_rd_data),
    .status  (q_status)
  );

  // sum divided by sample count, truncated toward zero
  tama_div u_div (
    .clk         (clk),
    .rst         (rst),
    .q_status    (q_status),
    .q_data      (q_rd_data),
    .q_rd        (q_rd),
    .pop         (pop),
    .empty       (empty),
    .average_x   (average_x),
    .average_y   (average_y),
    .average_z   (average_z),
    .window_full (window_full)
  );

endmodule

`default_nettype wire

// ===== test/three_axis_moving_average_tb.sv =====
`default_nettype none

// one expected average beat
typedef struct {
  tama_pkg::sample_t avg_x;
  tama_pkg::sample_t avg_y;
  tama_pkg::sample_t avg_z;
  logic              window_full;
} average_beat_t;

class average_scoreboard;
  tama_pkg::sample_t history [tama_pkg::WINDOW][tama_pkg::AXES];
  tama_pkg::sum_t    axis_sum [tama_pkg::AXES];
  int                held;
  int                next_slot;
  average_beat_t     pending_averages [$];
  int                failures;

  function new();
    foreach (axis_sum[a]) axis_sum[a] = '0;
    held = 0;
    next_slot = 0;
    failures = 0;
  endfunction

  // update the windowed sums for one accepted sample beat and queue the averages
  function void note_sample(tama_pkg::sample_t x, tama_pkg::sample_t y, tama_pkg::sample_t z);
    tama_pkg::sample_t s [tama_pkg::AXES];
    tama_pkg::sample_t avg [tama_pkg::AXES];
    bit                was_full;
    average_beat_t     beat;
    s[0] = x;
    s[1] = y;
    s[2] = z;
    was_full = (held == tama_pkg::WINDOW);
    if (!was_full) held++;
    for (int a = 0; a < tama_pkg::AXES; a++) begin
      if (was_full) axis_sum[a] = axis_sum[a] - history[next_slot][a];
      axis_sum[a] = axis_sum[a] + s[a];
      history[next_slot][a] = s[a];
      avg[a] = tama_pkg::sample_t'(int'(axis_sum[a]) / held);
    end
    next_slot = (next_slot + 1) % tama_pkg::WINDOW;
    beat.avg_x = avg[0];
    beat.avg_y = avg[1];
    beat.avg_z = avg[2];
    beat.window_full = (held == tama_pkg::WINDOW);
    pending_averages.push_back(beat);
  endfunction

  function void check_average(tama_pkg::sample_t ax, tama_pkg::sample_t ay,
                              tama_pkg::sample_t az, logic wf);
    average_beat_t exp_beat;
    if (pending_averages.size() == 0) begin
      $error("unexpected average beat: x %0d y %0d z %0d full %0b", ax, ay, az, wf);
      failures++;
      return;
    end
    exp_beat = pending_averages.pop_front();
    if (ax !== exp_beat.avg_x) begin
      $error("average_x mismatch: expected %0d, got %0d", exp_beat.avg_x, ax);
      failures++;
    end
    if (ay !== exp_beat.avg_y) begin
      $error("average_y mismatch: expected %0d, got %0d", exp_beat.avg_y, ay);
      failures++;
    end
    if (az !== exp_beat.avg_z) begin
      $error("average_z mismatch: expected %0d, got %0d", exp_beat.avg_z, az);
      failures++;
    end
    if (wf !== exp_beat.window_full) begin
      $error("window_full mismatch: expected %0b, got %0b", exp_beat.window_full, wf);
      failures++;
    end
  endfunction

  function int pending();
    return pending_averages.size();
  endfunction
endclass

module three_axis_moving_average_tb;

  localparam tama_pkg::sample_t SAMPLE_MAX = 16'h7FFF;
  localparam tama_pkg::sample_t SAMPLE_MIN = 16'h8000;

  // random beats per phase
  localparam int PHASE_BEATS = 133;
  // the receiver stops popping for HOLD_CYCLES once this many averages have come back
  localparam int HOLD_AT     = 60;
  localparam int HOLD_CYCLES = 300;
  // margin after the last expected average for a stray extra beat to show up
  localparam int DRAIN_CYCLES = 100;
  localparam int CYCLE_LIMIT  = 200000;

  logic              clk = 1'b0;
  logic              rst = 1'b1;
  logic              push = 1'b0;
  logic              full;
  tama_pkg::sample_t sample_x = '0;
  tama_pkg::sample_t sample_y = '0;
  tama_pkg::sample_t sample_z = '0;
  logic              empty;
  logic              pop = 1'b0;
  tama_pkg::sample_t average_x;
  tama_pkg::sample_t average_y;
  tama_pkg::sample_t average_z;
  logic              window_full;

  // idle chances in percent, changed by the main sequence per phase
  int send_idle_pct = 15;
  int recv_idle_pct = 46;
  int popped = 0;
  int cycles = 0;

  average_scoreboard avg_sb = new();

  three_axis_moving_average u_dut (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .full       (full),
    .sample_x   (sample_x),
    .sample_y   (sample_y),
    .sample_z   (sample_z),
    .empty      (empty),
    .pop        (pop),
    .average_x  (average_x),
    .average_y  (average_y),
    .average_z  (average_z),
    .window_full(window_full)
  );

  initial begin
    forever #4 clk = ~clk;
  end

  // watchdog on total run length
  initial begin
    forever begin
      @(posedge clk);
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
        $display("Regression FAIL");
        $finish;
      end
    end
  end

  // offer one sample beat, with random idle cycles in front of it
  // push stays high on return so back-to-back beats need no extra assignment
  task automatic send_sample(input tama_pkg::sample_t x, input tama_pkg::sample_t y,
                             input tama_pkg::sample_t z);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      push <= 1'b0;
      @(posedge clk);
    end
    push     <= 1'b1;
    sample_x <= x;
    sample_y <= y;
    sample_z <= z;
    @(posedge clk);
    // full read right after the edge is the value the dut saw at that edge
    while (full) @(posedge clk);
    avg_sb.note_sample(x, y, z);
  endtask

  // mix of full-range values, corners and small values around zero
  // small values make the truncation toward zero show up in the averages
  function automatic tama_pkg::sample_t pick_sample();
    case ($urandom_range(0, 9))
      0, 1, 2, 3: return tama_pkg::sample_t'($urandom());
      4, 5: begin
        case ($urandom_range(0, 4))
          0: return SAMPLE_MAX;
          1: return SAMPLE_MIN;
          2: return tama_pkg::sample_t'(-1);
          3: return tama_pkg::sample_t'(1);
          default: return tama_pkg::sample_t'(0);
        endcase
      end
      default: return tama_pkg::sample_t'(int'($urandom_range(0, 40)) - 20);
    endcase
  endfunction

  task automatic send_random(input int beats);
    for (int i = 0; i < beats; i++) send_sample(pick_sample(), pick_sample(), pick_sample());
  endtask

  // receiver: random pop with one long hold-off so the front and queue fill up
  initial begin
    bit held_off;
    held_off = 1'b0;
    wait (rst == 1'b0);
    forever begin
      if (!held_off && popped == HOLD_AT) begin
        held_off = 1'b1;
        pop <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end
      pop <= ($urandom_range(0, 99) >= recv_idle_pct);
      @(posedge clk);
      if (pop && !empty) begin
        avg_sb.check_average(average_x, average_y, average_z, window_full);
        popped++;
      end
    end
  end

  initial begin
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // phase 1: sender idles a little, receiver idles a lot

    // fill the window with x and y at the extremes and z at -1, first beats average over a partial count
    repeat (tama_pkg::WINDOW) send_sample(SAMPLE_MAX, SAMPLE_MIN, tama_pkg::sample_t'(-1));
    // swap extremes so the oldest samples leave a full window at the sum limits
    repeat (tama_pkg::WINDOW) send_sample(SAMPLE_MIN, SAMPLE_MAX, tama_pkg::sample_t'(1));
    // small odd values, negative sums must truncate toward zero
    send_sample(tama_pkg::sample_t'(-1), tama_pkg::sample_t'(1), tama_pkg::sample_t'(-3));
    send_sample(tama_pkg::sample_t'(5), tama_pkg::sample_t'(-5), tama_pkg::sample_t'(0));
    send_sample(tama_pkg::sample_t'(0), tama_pkg::sample_t'(0), tama_pkg::sample_t'(0));
    send_sample(tama_pkg::sample_t'(-7), tama_pkg::sample_t'(7), SAMPLE_MIN);
    send_random(PHASE_BEATS);

    // phase 2: roles swapped
    send_idle_pct = 46;
    recv_idle_pct = 15;
    send_random(PHASE_BEATS);

    // phase 3: both sides at full rate
    send_idle_pct = 0;
    recv_idle_pct = 0;
    send_random(PHASE_BEATS);
    push <= 1'b0;

    while (avg_sb.pending() != 0) @(posedge clk);
    // give any stray extra beat a chance to show up
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (avg_sb.failures == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

`default_nettype wire
